/* rtl/tef_pkg.sv */
// Package for the timer expiry forwarding block.
// Holds field widths, the resolution reset value and the register address; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tef_pkg;
    localparam int FIELD_W = 63;
    localparam int RES_W   = 32;
    localparam logic [RES_W-1:0] RES_RESET = 32'd10000000;
    localparam logic [1:0] ADDR_RES = 2'd0;
endpackage
`default_nettype wire

/* rtl/tef_divider.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Uses tef_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
module tef_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [tef_pkg::FIELD_W-1:0]   dividend,
    input  wire logic [tef_pkg::FIELD_W-1:0]   divisor,
    input  wire logic [tef_pkg::FIELD_W-1:0]   tag_a,
    input  wire logic [tef_pkg::FIELD_W-1:0]   tag_b,
    input  wire logic                          tag_c,
    output logic                               out_valid,
    output logic [tef_pkg::FIELD_W-1:0]        quotient,
    output logic [tef_pkg::FIELD_W-1:0]        rem_out,
    output logic [tef_pkg::FIELD_W-1:0]        div_out,
    output logic [tef_pkg::FIELD_W-1:0]        tag_a_out,
    output logic [tef_pkg::FIELD_W-1:0]        tag_b_out,
    output logic                               tag_c_out
);
    import tef_pkg::*;
    localparam int N = FIELD_W;

    logic [N:0]         v_reg;
    logic [N-1:0]       rem_reg [N+1];
    logic [N-1:0]       quo_reg [N+1];
    logic [N-1:0]       dvs_reg [N+1];
    logic [N-1:0]       ta_reg  [N+1];
    logic [N-1:0]       tb_reg  [N+1];
    logic [N:0]         tc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= '0;
        quo_reg[0] <= dividend;
        dvs_reg[0] <= divisor;
        ta_reg[0]  <= tag_a;
        tb_reg[0]  <= tag_b;
        tc_reg[0]  <= tag_c;
    end

    // Each stage shifts one dividend bit into the partial remainder.
    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [N:0] trial;
        always_comb
        begin
            trial = {rem_reg[s], quo_reg[s][N-1]} - {1'b0, dvs_reg[s]};
        end
        always_ff @(posedge clk)
        begin
            if (!trial[N])
            begin
                rem_reg[s+1] <= trial[N-1:0];
            end
            else
            begin
                rem_reg[s+1] <= {rem_reg[s][N-2:0], quo_reg[s][N-1]};
            end
            quo_reg[s+1] <= {quo_reg[s][N-2:0], ~trial[N]};
            dvs_reg[s+1] <= dvs_reg[s];
            ta_reg[s+1]  <= ta_reg[s];
            tb_reg[s+1]  <= tb_reg[s];
            tc_reg[s+1]  <= tc_reg[s];
        end
    end

    assign out_valid = v_reg[N];
    assign quotient  = quo_reg[N];
    assign rem_out   = rem_reg[N];
    assign div_out   = dvs_reg[N];
    assign tag_a_out = ta_reg[N];
    assign tag_b_out = tb_reg[N];
    assign tag_c_out = tc_reg[N];
endmodule
`default_nettype wire

/* rtl/timer_expiry_forward.sv */
// Top level of the timer expiry forwarding block.
// Depends on tef_pkg and tef_divider.
//
// Usage: a request is a transfer taken when start is high and busy is low;
// busy is always low, so one request may enter every cycle. Each request
// yields exactly one result, shown for one cycle with done high, on
// new_expiry and overrun_count. The pipeline is a clamp and delta stage,
// the divider's input register and its 63 stages (one quotient bit per
// stage), a stage that forms quotient times period from the remainder,
// an advance stage and a final compare/output stage.
// Throughput is one request per cycle. The resolution register sits at
// APB address 0 and must only be written while no request is in flight.
// Reset clears all valid bits and loads the resolution with 10 ms.
// The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
`default_nettype none
module timer_expiry_forward #(
    parameter int TIME_BITS = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [1:0]                  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [tef_pkg::FIELD_W-1:0] current_expiry,
    input  wire logic [tef_pkg::FIELD_W-1:0] present_time,
    input  wire logic [tef_pkg::FIELD_W-1:0] period_ns,
    output logic                             done,
    output logic [tef_pkg::FIELD_W-1:0]      new_expiry,
    output logic [tef_pkg::FIELD_W-1:0]      overrun_count
);
    import tef_pkg::*;
    localparam int N = FIELD_W;
    localparam logic [N:0] TMAX = {{(N+1-(TIME_BITS-1)){1'b0}}, {(TIME_BITS-1){1'b1}}};

    logic [RES_W-1:0] res_reg;
    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign prdata = (paddr == ADDR_RES) ? res_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= RES_RESET;
        end
        else if (psel && penable && pwrite && paddr == ADDR_RES)
        begin
            res_reg <= pwdata;
        end
    end

    // Stage 1: clamp period, form delta and the expired flag.
    logic         s1_v_reg;
    logic [N-1:0] s1_exp_reg, s1_now_reg, s1_per_reg, s1_dlt_reg;
    logic         s1_expd_reg;
    logic [N-1:0] per_c;

    always_comb
    begin
        per_c = period_ns;
        if (per_c < {{(N-RES_W){1'b0}}, res_reg})
        begin
            per_c = {{(N-RES_W){1'b0}}, res_reg};
        end
        if (per_c == '0)
        begin
            per_c = {{(N-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_exp_reg  <= current_expiry;
        s1_now_reg  <= present_time;
        s1_per_reg  <= per_c;
        s1_expd_reg <= !(present_time < current_expiry);
        s1_dlt_reg  <= present_time - current_expiry;
    end

    // The divider carries expiry, now and the expired flag alongside.
    logic         d_v;
    logic [N-1:0] d_q, d_rem, d_per, d_exp, d_now;
    logic         d_expd;

    tef_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_v_reg),
        .dividend  (s1_expd_reg ? s1_dlt_reg : '0),
        .divisor   (s1_per_reg),
        .tag_a     (s1_exp_reg),
        .tag_b     (s1_now_reg),
        .tag_c     (s1_expd_reg),
        .out_valid (d_v),
        .quotient  (d_q),
        .rem_out   (d_rem),
        .div_out   (d_per),
        .tag_a_out (d_exp),
        .tag_b_out (d_now),
        .tag_c_out (d_expd)
    );

    // Stage M: for an expired request, quotient times period equals delta less
    // the remainder, so no multiplier is needed; q*per <= delta < 2^63.
    logic         m_v_reg, m_expd_reg;
    logic [N-1:0] m_q_reg, m_per_reg, m_exp_reg, m_now_reg, m_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_v_reg <= 1'b0;
        end
        else
        begin
            m_v_reg <= d_v;
        end
    end

    always_ff @(posedge clk)
    begin
        m_prod_reg <= d_now - d_exp - d_rem;
        m_q_reg    <= d_q;
        m_per_reg  <= d_per;
        m_exp_reg  <= d_exp;
        m_now_reg  <= d_now;
        m_expd_reg <= d_expd;
    end

    // Stage A: first advance, and whether it lies past the present time.
    logic         a_v_reg, a_expd_reg, a_pass_reg;
    logic [N-1:0] a_q_reg, a_exp_reg, a_per_reg;
    logic [N:0]   a_e1_reg;
    logic [N:0]   e1;

    assign e1 = {1'b0, m_exp_reg} + {1'b0, m_prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_e1_reg   <= e1;
        a_pass_reg <= (m_q_reg != '0) && (e1 > {1'b0, m_now_reg});
        a_q_reg    <= m_q_reg;
        a_exp_reg  <= m_exp_reg;
        a_per_reg  <= m_per_reg;
        a_expd_reg <= m_expd_reg;
    end

    // Final stage: advance by one more period, pick, saturate and present.
    logic         o_v_reg;
    logic [N-1:0] o_exp_reg, o_cnt_reg;
    logic [N:0]   e2;
    logic [N-1:0] exp_next, cnt_next;

    always_comb
    begin
        e2 = a_e1_reg + {1'b0, a_per_reg};
        if (!a_expd_reg)
        begin
            exp_next = a_exp_reg;
            cnt_next = '0;
        end
        else if (a_pass_reg)
        begin
            exp_next = (a_e1_reg > TMAX) ? TMAX[N-1:0] : a_e1_reg[N-1:0];
            cnt_next = a_q_reg;
        end
        else
        begin
            exp_next = (e2 > TMAX) ? TMAX[N-1:0] : e2[N-1:0];
            cnt_next = (a_q_reg == '1) ? a_q_reg : a_q_reg + {{(N-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
        end
        else
        begin
            o_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        o_exp_reg <= exp_next;
        o_cnt_reg <= cnt_next;
    end

    assign done          = o_v_reg;
    assign new_expiry    = o_exp_reg;
    assign overrun_count = o_cnt_reg;

    a_zero_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overrun_count == '0) |-> (new_expiry == $past(a_exp_reg)))
        else $error("zero overrun changed expiry");
    a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
        a_v_reg |=> done)
        else $error("result lost in final stage");
    a_busy_low: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");
endmodule
`default_nettype wire

/* verif/timer_expiry_forward_tb.sv */
// Self-checking testbench for timer_expiry_forward: directed and random forwarding
// requests with resolution register changes, checked against an in-bench predictor.
// Depends on tef_pkg and the timer_expiry_forward RTL.
`timescale 1ns / 1ps

class expiry_scoreboard;
    logic [62:0] exp_expiry_q[$];
    logic [62:0] exp_orun_q[$];
    logic [31:0] resolution;
    int          mismatches;

    function new();
        resolution = tef_pkg::RES_RESET;
        mismatches = 0;
    endfunction

    // Works out the forwarded expiry and overrun count for one accepted request.
    function void note_request(logic [62:0] expiry_in, logic [62:0] now_in,
                               logic [62:0] period_in);
        logic [63:0] expiry;
        logic [63:0] now;
        logic [63:0] period;
        logic [63:0] delta;
        logic [63:0] orun;
        expiry = {1'b0, expiry_in};
        now    = {1'b0, now_in};
        period = {1'b0, period_in};
        orun   = 64'd1;
        if (now < expiry) begin
            exp_expiry_q.push_back(expiry[62:0]);
            exp_orun_q.push_back(63'd0);
            return;
        end
        delta = now - expiry;
        if (period < {32'd0, resolution})
            period = {32'd0, resolution};
        if (period == 64'd0)
            period = 64'd1;
        if (delta >= period) begin
            orun   = delta / period;
            expiry = expiry + period * orun;
            if (expiry > now) begin
                exp_expiry_q.push_back(expiry[62:0]);
                exp_orun_q.push_back(orun[62:0]);
                return;
            end
            orun = orun + 64'd1;
        end
        expiry = expiry + period;
        if (expiry[63])
            expiry = {1'b0, {63{1'b1}}};
        if (orun[63])
            orun = {1'b0, {63{1'b1}}};
        exp_expiry_q.push_back(expiry[62:0]);
        exp_orun_q.push_back(orun[62:0]);
    endfunction

    function void check_result(logic [62:0] got_expiry, logic [62:0] got_orun);
        logic [62:0] want_expiry;
        logic [62:0] want_orun;
        if (exp_expiry_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result expiry=%0d overrun=%0d",
                         got_expiry, got_orun);
            return;
        end
        want_expiry = exp_expiry_q.pop_front();
        want_orun   = exp_orun_q.pop_front();
        if (got_expiry !== want_expiry || got_orun !== want_orun) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: expiry exp %0d got %0d, overrun exp %0d got %0d",
                         want_expiry, got_expiry, want_orun, got_orun);
        end
    endfunction

    function int pending();
        return exp_expiry_q.size();
    endfunction
endclass

module timer_expiry_forward_tb;
    localparam int LATENCY = 68;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [62:0] TMAX = {63{1'b1}};

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [62:0] current_expiry;
    logic [62:0] present_time;
    logic [62:0] period_ns;
    logic        done;
    logic [62:0] new_expiry;
    logic [62:0] overrun_count;

    expiry_scoreboard sb;
    int idle_cycles;

    timer_expiry_forward dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .current_expiry(current_expiry),
        .present_time(present_time), .period_ns(period_ns), .done(done),
        .new_expiry(new_expiry), .overrun_count(overrun_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        sb = new();
    end

    // Results and transfers are sampled at the edge; the watchdog counts quiet cycles.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_result(new_expiry, overrun_count);
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timer_expiry_forward regression: fail");
                $finish;
            end
        end
    end

    task automatic write_resolution(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tef_pkg::ADDR_RES;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.resolution = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_request(logic [62:0] e, logic [62:0] n, logic [62:0] p,
                                bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        current_expiry <= e;
        present_time   <= n;
        period_ns      <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(e, n, p);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [62:0] rand63();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[62:0];
    endfunction

    // Mix of scales so short deltas, large quotients and saturation all occur.
    function automatic logic [62:0] rand_span();
        case ($urandom_range(0, 3))
            0: return 63'($urandom_range(0, 100));
            1: return 63'($urandom());
            2: return rand63() >> $urandom_range(0, 62);
            default: return rand63();
        endcase
    endfunction

    task automatic random_phase(int count);
        logic [62:0] e;
        logic [62:0] n;
        logic [62:0] p;
        bit gaps;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0)
                gaps = $urandom_range(0, 2) != 0;
            e = rand_span();
            case ($urandom_range(0, 4))
                0: n = rand63();
                1: n = e;
                default: n = (TMAX - e > 63'h7fff_ffff_ffff) ? e + rand_span() : TMAX;
            endcase
            if (n < e && $urandom_range(0, 3) != 0)
                n = e;
            p = ($urandom_range(0, 2) == 0) ? 63'($urandom_range(0, 20000000))
                                             : rand_span();
            send_request(e, n, p, gaps);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        current_expiry = '0;
        present_time = '0;
        period_ns = '0;
        idle_cycles = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests at the reset resolution of 10 ms.
        send_request(63'd100, 63'd50, 63'd10, 1'b0);
        send_request(63'd100, 63'd100, 63'd10, 1'b0);
        send_request(63'd0, 63'd0, 63'd0, 1'b0);
        send_request(63'd0, 63'd25000000, 63'd0, 1'b0);
        send_request(63'd0, 63'd30000000, 63'd10000000, 1'b0);
        send_request(63'd0, TMAX, 63'd20000000, 1'b0);
        send_request(TMAX, TMAX, TMAX, 1'b0);
        send_request(TMAX - 63'd5, TMAX, 63'd3, 1'b0);
        send_request(63'd0, TMAX, TMAX, 1'b0);
        send_request(TMAX, 63'd0, 63'd1, 1'b0);
        drain();

        // Zero resolution: period floor of 1 ns and saturated overrun counts.
        write_resolution(32'd0);
        send_request(63'd0, TMAX, 63'd0, 1'b0);
        send_request(63'd0, TMAX, 63'd1, 1'b0);
        send_request(63'd5, 63'd5, 63'd0, 1'b0);
        send_request(63'd7, 63'd1000, 63'd3, 1'b0);
        send_request(TMAX - 63'd1, TMAX, 63'd0, 1'b0);
        random_phase(120);
        drain();

        write_resolution(32'hFFFF_FFFF);
        send_request(63'd0, TMAX, 63'd1, 1'b0);
        send_request(63'd1, 63'd1, 63'd1, 1'b0);
        send_request(TMAX - 63'd10, TMAX, 63'd0, 1'b0);
        random_phase(150);
        drain();

        write_resolution(32'd1);
        random_phase(130);
        drain();

        write_resolution($urandom());
        random_phase(130);
        drain();

        write_resolution(tef_pkg::RES_RESET);
        random_phase(100);
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("timer_expiry_forward regression: pass");
        else
            $display("timer_expiry_forward regression: fail");
        $finish;
    end
endmodule
